// File: src/mhpq_pkg.sv
// Package for the min-heap priority queue: field widths, operation and status codes.
// No dependencies.
`default_nettype none
package mhpq_pkg;
    localparam int unsigned DefCapacity = 256;
    localparam int unsigned KeyW = 32;
    localparam int unsigned TagW = 16;
    localparam int unsigned CountW = 9;

    typedef enum logic [1:0] {
        K_INSERT  = 2'd0,
        K_DEL_MIN = 2'd1,
        K_DEL_MAX = 2'd2,
        K_PEEK_MAX = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        S_OK    = 2'd0,
        S_FULL  = 2'd1,
        S_EMPTY = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]        kind;
        logic [KeyW-1:0]   key;
        logic [TagW-1:0]   tag;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [KeyW-1:0]   out_key;
        logic [TagW-1:0]   out_tag;
        logic [KeyW-1:0]   min_key;
        logic [TagW-1:0]   min_tag;
        logic [CountW-1:0] count;
    } t_rsp;

    typedef struct packed {
        logic [KeyW-1:0] key;
        logic [TagW-1:0] tag;
    } t_entry;

    // Signed compare of two keys
    function automatic logic key_less(input logic [KeyW-1:0] a, input logic [KeyW-1:0] b);
        key_less = $signed(a) < $signed(b);
    endfunction
endpackage
`default_nettype wire

// File: src/mhpq_if.sv
// Valid/ready channel interface carrying one request or one result.
// Depends on mhpq_pkg.
`default_nettype none
interface mhpq_req_if;
    logic            valid;
    logic            ready;
    mhpq_pkg::t_req  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface mhpq_rsp_if;
    logic            valid;
    logic            ready;
    mhpq_pkg::t_rsp  data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: src/mhpq_store.sv
// Heap entry memory: one write port, one read port, registered read data.
// Depends on mhpq_pkg.
`default_nettype none
module mhpq_store #(
    parameter int unsigned AW = 8
) (
    input  wire                  i_clk,
    input  wire                  i_we,
    input  wire [AW-1:0]         i_waddr,
    input  wire mhpq_pkg::t_entry i_wdata,
    input  wire [AW-1:0]         i_raddr,
    output mhpq_pkg::t_entry     o_rdata
);
    import mhpq_pkg::*;

    t_entry r_mem [2**AW];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: src/min_heap_priority_queue_unit.sv
// Top level of the min-heap priority queue: control sequencer around the entry memory.
// Depends on mhpq_pkg, mhpq_if, mhpq_store.
//
//  channel | dir | payload                                     | accept
//  i_req   | in  | kind, key, tag                              | valid & ready
//  o_rsp   | out | status, out_key, out_tag, min_key, min_tag, | valid & ready
//          |     | count                                       |
//
// One request at a time; all memory traffic goes through one read and one write
// port. A sift-up step reads the parent, then compares; a sift-down step reads
// the left child, then the right child, then compares.
// Delete/peek-max scans the leaf slots, from count/2 upward, for the largest key.
// Reset clears the state, the count and the output valid; the memory needs no
// clearing pass. A result waits in the output register while o_rsp stalls; the
// next request is still taken, and its result holds in ST_DONE until the
// register frees.
`default_nettype none
module min_heap_priority_queue_unit #(
    parameter int unsigned CAPACITY = mhpq_pkg::DefCapacity
) (
    input wire i_clk,
    input wire i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);
    import mhpq_pkg::*;

    localparam int unsigned AW = (CAPACITY <= 2) ? 1 : $clog2(CAPACITY);
    localparam int unsigned CW = $clog2(CAPACITY + 1);

    typedef enum logic [11:0] {
        ST_IDLE   = 12'b000000000001,
        ST_RDROOT = 12'b000000000010, // wait root read
        ST_UPRD   = 12'b000000000100, // read parent
        ST_UPCMP  = 12'b000000001000,
        ST_DNRDL  = 12'b000000010000, // read left child
        ST_DNRDR  = 12'b000000100000, // read right child
        ST_DNCMP  = 12'b000001000000,
        ST_SCAN   = 12'b000010000000,
        ST_SCANW  = 12'b000100000000,
        ST_LAST   = 12'b001000000000, // read last entry
        ST_MIN    = 12'b010000000000, // re-read root
        ST_DONE   = 12'b100000000000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_kind, n_kind;
    logic [1:0]    r_status, n_status;
    t_entry        r_hold, n_hold;   // entry being sifted
    t_entry        r_out, n_out;     // removed / peeked entry
    t_entry        r_lch, n_lch;     // left child during sift-down
    logic [CW-1:0] r_pos, n_pos;     // current slot
    logic [CW-1:0] r_idx, n_idx;     // scan index
    logic [CW-1:0] r_best, n_best;   // max slot
    t_rsp          r_rsp, n_rsp;
    logic          r_ovalid, n_ovalid;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    t_entry        wdata, rdata;

    mhpq_store #(.AW(AW)) u_store (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic [CW-1:0] par, lch, rch;
    assign par = (r_pos - CW'(1)) >> 1;
    assign lch = CW'({r_pos, 1'b1});
    assign rch = lch + CW'(1);
    logic lch_ok, rch_ok;
    assign lch_ok = ({1'b0, r_pos} << 1) + (CW+1)'(1) < {1'b0, r_count};
    assign rch_ok = ({1'b0, r_pos} << 1) + (CW+1)'(2) < {1'b0, r_count};

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_rsp;

    // Sequencer
    always_comb begin
        n_state = r_state; n_count = r_count; n_kind = r_kind; n_status = r_status;
        n_hold = r_hold; n_out = r_out; n_lch = r_lch; n_pos = r_pos; n_idx = r_idx;
        n_best = r_best; n_rsp = r_rsp; n_ovalid = r_ovalid;
        we = 1'b0; waddr = '0; wdata = r_hold; raddr = '0;
        if (r_ovalid && o_rsp.ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (i_req.valid && i_req.ready) begin
                    n_kind = i_req.data.kind;
                    n_status = S_OK;
                    n_out = '0;
                    if (i_req.data.kind == K_INSERT) begin
                        if (r_count >= CW'(CAPACITY)) begin
                            n_status = S_FULL;
                            n_state = ST_MIN;
                        end else begin
                            n_hold = '{key: i_req.data.key, tag: i_req.data.tag};
                            n_pos = r_count;
                            n_count = r_count + CW'(1);
                            n_state = ST_UPRD;
                        end
                    end else if (r_count == '0) begin
                        n_status = S_EMPTY;
                        n_state = ST_MIN;
                    end else begin
                        raddr = '0;
                        n_state = ST_RDROOT;
                    end
                end
            end
            ST_RDROOT: begin
                // rdata is root
                if (r_kind == K_DEL_MIN) begin
                    n_out = rdata;
                    n_count = r_count - CW'(1);
                    raddr = AW'(r_count - CW'(1));
                    n_pos = '0;
                    n_state = ST_LAST;
                end else begin
                    n_out = rdata;
                    n_best = '0;
                    n_idx = r_count >> 1;
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_idx < r_count) begin
                    raddr = AW'(r_idx);
                    n_state = ST_SCANW;
                end else if (r_kind == K_PEEK_MAX) begin
                    n_state = ST_MIN;
                end else begin
                    n_count = r_count - CW'(1);
                    n_pos = r_best;
                    raddr = AW'(r_count - CW'(1));
                    n_state = (r_best < r_count - CW'(1)) ? ST_LAST : ST_MIN;
                end
            end
            ST_SCANW: begin
                if (key_less(r_out.key, rdata.key)) begin
                    n_out = rdata;
                    n_best = r_idx;
                end
                n_idx = r_idx + CW'(1);
                n_state = ST_SCAN;
            end
            ST_LAST: begin
                n_hold = rdata;
                if (r_kind == K_DEL_MIN) begin
                    n_state = (r_count == '0) ? ST_MIN : ST_DNRDL;
                end else begin
                    n_state = ST_UPRD;
                end
            end
            ST_UPRD: begin
                if (r_pos == '0) begin
                    we = 1'b1; waddr = '0; wdata = r_hold;
                    n_state = ST_MIN;
                end else begin
                    raddr = AW'(par);
                    n_state = ST_UPCMP;
                end
            end
            ST_UPCMP: begin
                we = 1'b1; waddr = AW'(r_pos);
                if (key_less(r_hold.key, rdata.key)) begin
                    wdata = rdata;
                    n_pos = par;
                    n_state = ST_UPRD;
                end else begin
                    wdata = r_hold;
                    n_state = ST_MIN;
                end
            end
            ST_DNRDL: begin
                if (lch_ok) begin
                    raddr = AW'(lch);
                    n_state = ST_DNRDR;
                end else begin
                    we = 1'b1; waddr = AW'(r_pos); wdata = r_hold;
                    n_state = ST_MIN;
                end
            end
            ST_DNRDR: begin
                n_lch = rdata;
                raddr = AW'(rch);
                n_state = ST_DNCMP;
            end
            ST_DNCMP: begin
                // pick smaller child, strict compares
                we = 1'b1; waddr = AW'(r_pos);
                if (rch_ok && key_less(rdata.key, r_lch.key)
                        && key_less(rdata.key, r_hold.key)) begin
                    wdata = rdata;
                    n_pos = rch;
                    n_state = ST_DNRDL;
                end else if (key_less(r_lch.key, r_hold.key)) begin
                    wdata = r_lch;
                    n_pos = lch;
                    n_state = ST_DNRDL;
                end else begin
                    wdata = r_hold;
                    n_state = ST_MIN;
                end
            end
            ST_MIN: begin
                raddr = '0;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                // root stays on rdata while the output register is busy
                if (!r_ovalid || o_rsp.ready) begin
                    n_rsp.status  = r_status;
                    n_rsp.out_key = r_out.key;
                    n_rsp.out_tag = r_out.tag;
                    n_rsp.min_key = (r_count != '0) ? rdata.key : '0;
                    n_rsp.min_tag = (r_count != '0) ? rdata.tag : '0;
                    n_rsp.count   = CountW'(r_count);
                    n_ovalid = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovalid <= n_ovalid;
        end
        r_kind <= n_kind; r_status <= n_status; r_hold <= n_hold; r_out <= n_out;
        r_lch <= n_lch; r_pos <= n_pos; r_idx <= n_idx; r_best <= n_best;
        r_rsp <= n_rsp;
    end

    // Checks
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY)) else $error("count beyond capacity");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> r_state != ST_IDLE)
        else $error("request taken without leaving idle");
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !o_rsp.ready) |=> r_ovalid && $stable(r_rsp))
        else $error("result dropped");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |=> (r_count == $past(r_count) ||
        r_count == $past(r_count) + CW'(1))) else $error("count jump");
endmodule
`default_nettype wire
